### design/gcb_pkg.sv
// ----------------------------------------------------------------------------
// gcb_pkg
// Shared constants, types and elaboration-time tables for the gamma,
// contrast and brightness ramp pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package gcb_pkg;

  // Field and register widths
  localparam int LVL_W  = 8;
  localparam int VAL_W  = 16;
  localparam int REG_W  = 14;
  localparam int IDX_W  = 2;
  localparam int LVLS   = 1 << LVL_W;

  // Fixed-point formats
  localparam int FRAC_BITS = 12;
  localparam int LOG_FB    = 28;
  localparam int EXP_FB    = 30;
  localparam int R_W       = EXP_FB + 1;
  localparam int N_W       = 4;
  localparam int D_W       = 31;
  localparam int Q_W       = 32;
  localparam int DIV_STEPS = 4;
  localparam int DIV_STAGES = Q_W / DIV_STEPS;
  localparam int NUM_HI_W  = D_W + FRAC_BITS - Q_W;
  localparam int P24_W     = 25;
  localparam int PC_W      = P24_W + REG_W;
  localparam int ACC_W     = 56;
  localparam int PROD_SHIFT = 24 + FRAC_BITS;
  localparam int BC_SHIFT   = 39;
  localparam int V_W        = ACC_W - PROD_SHIFT;

  // Register bounds and reset values
  localparam int ONE      = 1 << FRAC_BITS;
  localparam int GAMMA_LO = ONE >> 1;
  localparam int GAMMA_HI = ONE * 3;
  localparam int TENTH    = (ONE + 5) / 10;
  localparam int CB_HI    = ONE * 2;

  localparam logic [REG_W-1:0] GAMMA_RST      = REG_W'(ONE);
  localparam logic [REG_W-1:0] CONTRAST_RST   = REG_W'(ONE);
  localparam logic [REG_W-1:0] BRIGHTNESS_RST = REG_W'(ONE);
  localparam logic             CLAMP_RST      = 1'b1;

  // Register indexes
  localparam logic [IDX_W-1:0] CFG_GAMMA      = 2'd0;
  localparam logic [IDX_W-1:0] CFG_CONTRAST   = 2'd1;
  localparam logic [IDX_W-1:0] CFG_BRIGHTNESS = 2'd2;
  localparam logic [IDX_W-1:0] CFG_CLAMP      = 2'd3;

  // Saturated configuration seen by the datapath
  typedef struct packed {
    logic [REG_W-1:0] gamma;
    logic [REG_W-1:0] contrast;
    logic [REG_W-1:0] brightness;
    logic             clamp;
  } cfg_t;

  // Beat leaving the divider: exponent split into integer and fraction
  typedef struct packed {
    logic [LVL_W-1:0]  lvl;
    logic [N_W-1:0]    n;
    logic [LOG_FB-1:0] f;
    logic [R_W-1:0]    r;
  } exp_pl_t;

  // Beat leaving the exp2 chain
  typedef struct packed {
    logic [LVL_W-1:0] lvl;
    logic [N_W-1:0]   n;
    logic [R_W-1:0]   r;
  } pow_pl_t;

  typedef logic [D_W-1:0] d_tbl_t [LVLS];
  typedef logic [R_W-1:0] c_tbl_t [LOG_FB];

  function automatic logic [63:0] isqrt64(input logic [63:0] xin);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    x = xin;
    r = '0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // log2 of 1..255 in Q28 by repeated squaring
  function automatic logic [63:0] log2_q28(input int n);
    int e;
    logic [63:0] m;
    logic [63:0] res;
    e = 0;
    for (int k = 1; k < 8; k++) begin
      if ((n >> k) != 0) e = k;
    end
    m   = 64'(n) << (EXP_FB - e);
    res = 64'(e) << LOG_FB;
    for (int k = 1; k <= LOG_FB; k++) begin
      m = (m * m) >> EXP_FB;
      if (m >= (64'd1 << (EXP_FB + 1))) begin
        m   = m >> 1;
        res = res | (64'd1 << (LOG_FB - k));
      end
    end
    return res;
  endfunction

  // log2(255) - log2(level), clipped at zero
  function automatic d_tbl_t build_d_tbl();
    d_tbl_t t;
    logic [63:0] lt;
    logic [63:0] li;
    lt = log2_q28(255);
    for (int i = 0; i < LVLS; i++) begin
      if (i == 0) begin
        t[i] = '0;
      end else begin
        li   = log2_q28(i);
        t[i] = (li > lt) ? '0 : D_W'(lt - li);
      end
    end
    return t;
  endfunction

  // Factors 2^-(2^-(k+1)) in Q30
  function automatic c_tbl_t build_c_tbl();
    c_tbl_t t;
    logic [63:0] c;
    c = 64'd1 << (EXP_FB - 1);
    for (int k = 0; k < LOG_FB; k++) begin
      c    = isqrt64(c << EXP_FB);
      t[k] = R_W'(c);
    end
    return t;
  endfunction

  localparam d_tbl_t D_TBL = build_d_tbl();
  localparam c_tbl_t C_TBL = build_c_tbl();

endpackage
`default_nettype wire

### design/gcb_if.sv
// ----------------------------------------------------------------------------
// gcb_if
// Valid/ready channels for input levels and output ramp values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface gcb_level_if;
  logic                     valid;
  logic                     ready;
  logic [gcb_pkg::LVL_W-1:0] level;
  modport source (output valid, output level, input ready);
  modport sink   (input valid, input level, output ready);
endinterface

interface gcb_ramp_if;
  logic                     valid;
  logic                     ready;
  logic [gcb_pkg::VAL_W-1:0] ramp_value;
  modport source (output valid, output ramp_value, input ready);
  modport sink   (input valid, input ramp_value, output ready);
endinterface
`default_nettype wire

### design/gcb_div.sv
// ----------------------------------------------------------------------------
// gcb_div
// Log lookup and pipelined restoring divide y = (d << F) / gamma.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module gcb_div (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire [gcb_pkg::REG_W-1:0]   gamma,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire [gcb_pkg::LVL_W-1:0]   in_lvl,
  output logic                       out_valid,
  input  wire                        out_ready,
  output gcb_pkg::exp_pl_t           out_data
);

  localparam int NS = gcb_pkg::DIV_STAGES + 1;

  typedef struct packed {
    logic [gcb_pkg::LVL_W-1:0] lvl;
    logic [gcb_pkg::REG_W-1:0] rem;
    logic [gcb_pkg::Q_W-1:0]   nq;
  } div_pl_t;

  div_pl_t         pl_r [NS];
  logic [NS-1:0]   vld_r;
  logic [NS-1:0]   en;

  // Four quotient bits per stage; numerator bits shift out as quotient shifts in
  function automatic div_pl_t div_steps(input div_pl_t p, input logic [gcb_pkg::REG_W-1:0] g);
    div_pl_t q;
    logic [gcb_pkg::REG_W:0] t;
    q = p;
    for (int s = 0; s < gcb_pkg::DIV_STEPS; s++) begin
      t = {q.rem, q.nq[gcb_pkg::Q_W-1]};
      if (t >= {1'b0, g}) begin
        q.rem = gcb_pkg::REG_W'(t - {1'b0, g});
        q.nq  = {q.nq[gcb_pkg::Q_W-2:0], 1'b1};
      end else begin
        q.rem = t[gcb_pkg::REG_W-1:0];
        q.nq  = {q.nq[gcb_pkg::Q_W-2:0], 1'b0};
      end
    end
    return q;
  endfunction

  // Stall chain: a stage moves when it is empty or its successor moves
  assign en[NS-1] = !vld_r[NS-1] || out_ready;
  for (genvar i = 0; i < NS - 1; i++) begin : g_en
    assign en[i] = !vld_r[i] || en[i+1];
  end
  assign in_ready = en[0];

  // Stage 0: table lookup of the log difference
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en[0]) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pl_r[0].lvl <= in_lvl;
      pl_r[0].rem <= gcb_pkg::REG_W'(
        gcb_pkg::D_TBL[in_lvl][gcb_pkg::D_W-1 -: gcb_pkg::NUM_HI_W]);
      pl_r[0].nq  <= {gcb_pkg::D_TBL[in_lvl][gcb_pkg::D_W-gcb_pkg::NUM_HI_W-1:0],
                      gcb_pkg::FRAC_BITS'(0)};
    end
  end

  // Divide stages
  for (genvar i = 1; i < NS; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en[i]) begin
        vld_r[i] <= vld_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en[i]) begin
        pl_r[i] <= div_steps(pl_r[i-1], gamma);
      end
    end
  end

  assign out_valid    = vld_r[NS-1];
  assign out_data.lvl = pl_r[NS-1].lvl;
  assign out_data.n   = pl_r[NS-1].nq[gcb_pkg::Q_W-1 -: gcb_pkg::N_W];
  assign out_data.f   = pl_r[NS-1].nq[gcb_pkg::LOG_FB-1:0];
  assign out_data.r   = gcb_pkg::R_W'(1) << gcb_pkg::EXP_FB;

endmodule
`default_nettype wire

### design/gcb_exp.sv
// ----------------------------------------------------------------------------
// gcb_exp
// exp2 of the negated fraction: one Q30 multiply per stage, MSB first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module gcb_exp (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  gcb_pkg::exp_pl_t    in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output gcb_pkg::pow_pl_t    out_data
);

  localparam int NS = gcb_pkg::LOG_FB;

  gcb_pkg::exp_pl_t pl_r  [NS];
  gcb_pkg::exp_pl_t st_in [NS];
  logic [NS-1:0]    vld_r;
  logic [NS-1:0]    vld_in;
  logic [NS-1:0]    en;

  assign en[NS-1] = !vld_r[NS-1] || out_ready;
  for (genvar i = 0; i < NS - 1; i++) begin : g_en
    assign en[i] = !vld_r[i] || en[i+1];
  end
  assign in_ready = en[0];

  assign st_in[0]  = in_data;
  assign vld_in[0] = in_valid;
  for (genvar i = 1; i < NS; i++) begin : g_link
    assign st_in[i]  = pl_r[i-1];
    assign vld_in[i] = vld_r[i-1];
  end

  for (genvar i = 0; i < NS; i++) begin : g_stage
    logic [2*gcb_pkg::R_W-1:0] prod;
    logic [gcb_pkg::R_W-1:0]   r_nxt;

    // Stage i applies fraction bit LOG_FB-1-i
    assign prod  = st_in[i].r * gcb_pkg::C_TBL[i];
    assign r_nxt = st_in[i].f[gcb_pkg::LOG_FB-1-i] ? prod[gcb_pkg::EXP_FB +: gcb_pkg::R_W]
                                                    : st_in[i].r;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en[i]) begin
        vld_r[i] <= vld_in[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en[i]) begin
        pl_r[i] <= '{lvl: st_in[i].lvl, n: st_in[i].n, f: st_in[i].f, r: r_nxt};
      end
    end
  end

  assign out_valid    = vld_r[NS-1];
  assign out_data.lvl = pl_r[NS-1].lvl;
  assign out_data.n   = pl_r[NS-1].n;
  assign out_data.r   = pl_r[NS-1].r;

endmodule
`default_nettype wire

### design/gcb_out.sv
// ----------------------------------------------------------------------------
// gcb_out
// Power rounding, contrast scaling, brightness offset, band clamp, saturate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module gcb_out (
  input  wire                        clk,
  input  wire                        rst_n,
  input  gcb_pkg::cfg_t              cfg,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  gcb_pkg::pow_pl_t           in_data,
  output logic                       out_valid,
  input  wire                        out_ready,
  output logic [gcb_pkg::VAL_W-1:0]  out_value
);

  logic [2:0] vld_r;
  logic [2:0] en;

  logic [gcb_pkg::LVL_W-1:0] lvl1_r, lvl2_r;
  logic [gcb_pkg::P24_W-1:0] p24_r, p24_nxt;
  logic [gcb_pkg::PC_W-1:0]  pc_r;
  logic [gcb_pkg::VAL_W-1:0] val_r, val_nxt;

  logic [gcb_pkg::R_W-1:0]         shr;
  logic signed [gcb_pkg::ACC_W-1:0] acc;
  logic signed [gcb_pkg::REG_W:0]   bc;
  logic signed [gcb_pkg::V_W-1:0]   v;
  logic signed [gcb_pkg::V_W-1:0]   base;
  logic signed [gcb_pkg::V_W-1:0]   hi;
  logic signed [gcb_pkg::V_W-1:0]   lo;
  logic signed [gcb_pkg::V_W-1:0]   vc;

  assign en[2] = !vld_r[2] || out_ready;
  assign en[1] = !vld_r[1] || en[2];
  assign en[0] = !vld_r[0] || en[1];
  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_valid;
      if (en[1]) vld_r[1] <= vld_r[0];
      if (en[2]) vld_r[2] <= vld_r[1];
    end
  end

  // Stage 1: integer part of exponent as a shift, round Q30 to Q24; level zero is zero
  always_comb begin
    shr     = in_data.r >> in_data.n;
    p24_nxt = gcb_pkg::P24_W'((gcb_pkg::R_W'(shr) + gcb_pkg::R_W'(32)) >> 6);
    if (in_data.lvl == '0) p24_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p24_r  <= p24_nxt;
      lvl1_r <= in_data.lvl;
    end
  end

  // Stage 2: power times contrast
  always_ff @(posedge clk) begin
    if (en[1]) begin
      pc_r   <= gcb_pkg::PC_W'(p24_r) * gcb_pkg::PC_W'(cfg.contrast);
      lvl2_r <= lvl1_r;
    end
  end

  // Stage 3: times 65535, add brightness offset, round, clamp
  always_comb begin
    bc  = $signed({1'b0, cfg.brightness}) - $signed({1'b0, cfg.contrast});
    acc = $signed({1'b0, pc_r, 16'b0})
        - $signed({{(gcb_pkg::ACC_W-gcb_pkg::PC_W){1'b0}}, pc_r})
        + $signed({{(gcb_pkg::ACC_W-gcb_pkg::BC_SHIFT-gcb_pkg::REG_W-1){bc[gcb_pkg::REG_W]}},
                   bc, {gcb_pkg::BC_SHIFT{1'b0}}})
        + (gcb_pkg::ACC_W'(1) << (gcb_pkg::PROD_SHIFT - 1));
    v    = acc[gcb_pkg::ACC_W-1 -: gcb_pkg::V_W];
    base = $signed({{(gcb_pkg::V_W-gcb_pkg::LVL_W-8){1'b0}}, lvl2_r, 8'b0});
    hi   = base + gcb_pkg::V_W'(32768);
    lo   = base - gcb_pkg::V_W'(32768);
    vc   = v;
    if (cfg.clamp) begin
      if (vc > hi) vc = hi;
      if (vc < lo) vc = lo;
    end
    if (vc < 0) begin
      val_nxt = '0;
    end else if (vc > gcb_pkg::V_W'(65535)) begin
      val_nxt = '1;
    end else begin
      val_nxt = vc[gcb_pkg::VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) val_r <= val_nxt;
  end

  assign out_valid = vld_r[2];
  assign out_value = val_r;

endmodule
`default_nettype wire

### design/gamma_contrast_brightness_curve_core.sv
// ----------------------------------------------------------------------------
// gamma_contrast_brightness_curve_core
// Display ramp generator: gamma power, contrast, brightness and band clamp.
// ----------------------------------------------------------------------------
// Takes one 8-bit level per beat and returns one 16-bit ramp value per beat,
// one beat per clock when the output is taken every cycle. The pipeline runs
// the log lookup and the 4-bit-per-stage divide by gamma, then the exp2 chain
// (one Q30 multiply per stage), then rounding, scaling and clamping. Each
// stage holds its own valid bit, so bubbles close up under an output stall.
// The user must write registers through the cfg_ port only while no beat is
// in flight; the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
module gamma_contrast_brightness_curve_core (
  input  wire                        clk,
  input  wire                        rst_n,
  gcb_level_if.sink                  in_chan,
  gcb_ramp_if.source                 out_chan,
  input  wire                        cfg_we,
  input  wire [gcb_pkg::IDX_W-1:0]   cfg_index,
  input  wire [gcb_pkg::REG_W-1:0]   cfg_wdata
);

  logic [gcb_pkg::REG_W-1:0] gamma_r, contrast_r, brightness_r;
  logic                      clamp_r;
  gcb_pkg::cfg_t             cfg;

  logic             d2e_valid, d2e_ready;
  gcb_pkg::exp_pl_t d2e_data;
  logic             e2o_valid, e2o_ready;
  gcb_pkg::pow_pl_t e2o_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_r      <= gcb_pkg::GAMMA_RST;
      contrast_r   <= gcb_pkg::CONTRAST_RST;
      brightness_r <= gcb_pkg::BRIGHTNESS_RST;
      clamp_r      <= gcb_pkg::CLAMP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        gcb_pkg::CFG_GAMMA:      gamma_r      <= cfg_wdata;
        gcb_pkg::CFG_CONTRAST:   contrast_r   <= cfg_wdata;
        gcb_pkg::CFG_BRIGHTNESS: brightness_r <= cfg_wdata;
        gcb_pkg::CFG_CLAMP:      clamp_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Saturate to legal bounds
  always_comb begin
    cfg.gamma = gamma_r;
    if (gamma_r < gcb_pkg::REG_W'(gcb_pkg::GAMMA_LO)) cfg.gamma = gcb_pkg::REG_W'(gcb_pkg::GAMMA_LO);
    if (gamma_r > gcb_pkg::REG_W'(gcb_pkg::GAMMA_HI)) cfg.gamma = gcb_pkg::REG_W'(gcb_pkg::GAMMA_HI);
    cfg.contrast = contrast_r;
    if (contrast_r < gcb_pkg::REG_W'(gcb_pkg::TENTH)) cfg.contrast = gcb_pkg::REG_W'(gcb_pkg::TENTH);
    if (contrast_r > gcb_pkg::REG_W'(gcb_pkg::CB_HI)) cfg.contrast = gcb_pkg::REG_W'(gcb_pkg::CB_HI);
    cfg.brightness = brightness_r;
    if (brightness_r < gcb_pkg::REG_W'(gcb_pkg::TENTH)) begin
      cfg.brightness = gcb_pkg::REG_W'(gcb_pkg::TENTH);
    end
    if (brightness_r > gcb_pkg::REG_W'(gcb_pkg::CB_HI)) begin
      cfg.brightness = gcb_pkg::REG_W'(gcb_pkg::CB_HI);
    end
    cfg.clamp = clamp_r;
  end

  gcb_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .gamma     (cfg.gamma),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_lvl    (in_chan.level),
    .out_valid (d2e_valid),
    .out_ready (d2e_ready),
    .out_data  (d2e_data)
  );

  gcb_exp u_exp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (d2e_valid),
    .in_ready  (d2e_ready),
    .in_data   (d2e_data),
    .out_valid (e2o_valid),
    .out_ready (e2o_ready),
    .out_data  (e2o_data)
  );

  gcb_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (e2o_valid),
    .in_ready  (e2o_ready),
    .in_data   (e2o_data),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_value (out_chan.ramp_value)
  );

endmodule
`default_nettype wire
